/* hdl/clas_pkg.sv */
// Shared types and constants for the command line argument splitter.
`timescale 1ns / 1ps

package clas_pkg;

	localparam int UNIT_W = 16;
	localparam int ARG_W  = 12;
	localparam int BS_W   = 6;

	localparam logic [UNIT_W-1:0] CH_BACKSLASH = 16'h005C;
	localparam logic [UNIT_W-1:0] CH_QUOTE     = 16'h0022;
	localparam logic [UNIT_W-1:0] CH_SPACE     = 16'h0020;
	localparam logic [UNIT_W-1:0] CH_TAB       = 16'h0009;
	localparam logic [UNIT_W-1:0] CH_NUL       = 16'h0000;

	typedef struct packed {
		logic [UNIT_W-1:0] code_unit;
		logic              line_end;
	} in_item_t;

	typedef struct packed {
		logic [UNIT_W-1:0] out_unit;
		logic              arg_end;
		logic [ARG_W-1:0]  arg_number;
		logic              run_last;
		logic              line_done;
		logic              slash_overflow;
	} out_item_t;

	// which kind of result the datapath emits next
	typedef enum logic [1:0] {
		SEL_BS    = 2'd0,
		SEL_CHAR  = 2'd1,
		SEL_CLOSE = 2'd2
	} sel_t;

	typedef struct packed {
		logic load;
		logic emit;
		sel_t sel;
		logic run_last;
	} ctrl_cmd_t;

	typedef struct packed {
		logic item_empty;
		logic bs_zero;
		logic bs_one;
		logic has_char;
		logic has_close;
		logic out_free;
	} dp_status_t;

endpackage

/* hdl/clas_in_if.sv */
// Input channel: one code unit per transaction.
`timescale 1ns / 1ps

interface clas_in_if;
	logic               valid;
	logic               ready;
	clas_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hdl/clas_out_if.sv */
// Output channel: one argument character or terminator per transaction.
`timescale 1ns / 1ps

interface clas_out_if;
	logic                valid;
	logic                ready;
	clas_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* hdl/clas_datapath.sv */
// Parser state, per-item emission plan and output register.
`timescale 1ns / 1ps

module clas_datapath #(
	parameter int MAX_BACKSLASHES = 62,
	parameter int MAX_ARGUMENTS   = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  clas_pkg::in_item_t    in_data,
	input  clas_pkg::ctrl_cmd_t   cmd,
	output clas_pkg::dp_status_t  st,
	output clas_pkg::out_item_t   out_data,
	output logic                  out_valid,
	input  logic                  out_ready
);

	localparam int IdxLimInt = (MAX_ARGUMENTS - 1 > 4095) ? 4095 : MAX_ARGUMENTS - 1;
	localparam logic [clas_pkg::ARG_W-1:0] IdxLim = clas_pkg::ARG_W'(IdxLimInt);
	localparam logic [clas_pkg::BS_W-1:0]  MaxBs  = clas_pkg::BS_W'(MAX_BACKSLASHES);

	// parser state
	logic                          in_arg_q, in_quote_q, pend_q, ovf_q;
	logic [clas_pkg::BS_W-1:0]     held_q;
	logic [clas_pkg::ARG_W-1:0]    idx_q;

	// plan of the item being emitted
	logic [clas_pkg::BS_W-1:0]     bs_left_q;
	logic                          has_char_q, has_close_q, last_q, item_ovf_q;
	logic [clas_pkg::UNIT_W-1:0]   char_q;
	logic [clas_pkg::ARG_W-1:0]    item_idx_q;

	logic                          out_valid_q;
	clas_pkg::out_item_t           out_q;

	// next-state and plan computed from the offered item
	logic                          ia_n, iq_n, pend_n, ovf_n, ch_v, cl;
	logic [clas_pkg::BS_W-1:0]     hb_n, n_bs;
	logic [clas_pkg::UNIT_W-1:0]   chr;
	logic [clas_pkg::ARG_W-1:0]    idx_n;
	logic [clas_pkg::UNIT_W-1:0]   u;
	logic                          last, is_sep;

	always_comb begin
		u      = in_data.code_unit;
		last   = in_data.line_end;
		is_sep = (u == clas_pkg::CH_SPACE) || (u == clas_pkg::CH_TAB);
		ia_n   = in_arg_q;
		iq_n   = in_quote_q;
		pend_n = 1'b0;
		ovf_n  = ovf_q;
		hb_n   = held_q;
		n_bs   = '0;
		ch_v   = 1'b0;
		chr    = u;
		cl     = 1'b0;
		if (pend_q && u == clas_pkg::CH_QUOTE) begin
			ch_v = 1'b1;
		end else if (u == clas_pkg::CH_BACKSLASH) begin
			ia_n = 1'b1;
			if (held_q < MaxBs) begin
				hb_n = held_q + 1'b1;
			end else begin
				ovf_n = 1'b1;
			end
		end else if (u == clas_pkg::CH_QUOTE) begin
			ia_n = 1'b1;
			n_bs = held_q >> 1;
			hb_n = '0;
			if (held_q[0]) begin
				ch_v = 1'b1;
			end else begin
				iq_n   = ~in_quote_q;
				pend_n = in_quote_q & ~last;
			end
		end else if (is_sep) begin
			if (in_arg_q) begin
				n_bs = held_q;
				hb_n = '0;
				if (in_quote_q) begin
					ch_v = 1'b1;
				end else begin
					cl   = 1'b1;
					ia_n = 1'b0;
				end
			end
		end else begin
			ia_n = 1'b1;
			n_bs = held_q;
			hb_n = '0;
			ch_v = 1'b1;
		end
		// final unit flushes held backslashes and closes an open argument
		if (last && ia_n) begin
			n_bs = n_bs + hb_n;
			hb_n = '0;
			cl   = 1'b1;
		end
		idx_n = (cl && idx_q < IdxLim) ? idx_q + 1'b1 : idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_arg_q    <= 1'b1;
			in_quote_q  <= 1'b0;
			pend_q      <= 1'b0;
			ovf_q       <= 1'b0;
			held_q      <= '0;
			idx_q       <= '0;
			bs_left_q   <= '0;
			has_char_q  <= 1'b0;
			has_close_q <= 1'b0;
			last_q      <= 1'b0;
			item_ovf_q  <= 1'b0;
			item_idx_q  <= '0;
		end else if (cmd.load) begin
			if (last) begin
				in_arg_q   <= 1'b1;
				in_quote_q <= 1'b0;
				pend_q     <= 1'b0;
				ovf_q      <= 1'b0;
				held_q     <= '0;
				idx_q      <= '0;
			end else begin
				in_arg_q   <= ia_n;
				in_quote_q <= iq_n;
				pend_q     <= pend_n;
				ovf_q      <= ovf_n;
				held_q     <= hb_n;
				idx_q      <= idx_n;
			end
			bs_left_q   <= n_bs;
			has_char_q  <= ch_v;
			has_close_q <= cl;
			last_q      <= last;
			item_ovf_q  <= ovf_n;
			item_idx_q  <= idx_q;
		end else if (cmd.emit) begin
			if (cmd.sel == clas_pkg::SEL_BS) begin
				bs_left_q <= bs_left_q - 1'b1;
			end
			if (cmd.sel == clas_pkg::SEL_CHAR) begin
				has_char_q <= 1'b0;
			end
			if (cmd.sel == clas_pkg::SEL_CLOSE) begin
				has_close_q <= 1'b0;
			end
		end
	end

	// a doubled quote already carries the quote in chr
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			char_q <= ch_v ? chr : clas_pkg::CH_NUL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.arg_number     <= item_idx_q;
			out_q.run_last       <= cmd.run_last;
			out_q.line_done      <= last_q;
			out_q.slash_overflow <= item_ovf_q;
			unique case (cmd.sel)
				clas_pkg::SEL_BS: begin
					out_q.out_unit <= clas_pkg::CH_BACKSLASH;
					out_q.arg_end  <= 1'b0;
				end
				clas_pkg::SEL_CHAR: begin
					out_q.out_unit <= char_q;
					out_q.arg_end  <= 1'b0;
				end
				clas_pkg::SEL_CLOSE: begin
					out_q.out_unit <= clas_pkg::CH_NUL;
					out_q.arg_end  <= 1'b1;
				end
				default: begin
					out_q.out_unit <= clas_pkg::CH_NUL;
					out_q.arg_end  <= 1'b1;
				end
			endcase
		end
	end

	assign st.item_empty = (n_bs == '0) && !ch_v && !cl;
	assign st.bs_zero    = (bs_left_q == '0);
	assign st.bs_one     = (bs_left_q == clas_pkg::BS_W'(1));
	assign st.has_char   = has_char_q;
	assign st.has_close  = has_close_q;
	assign st.out_free   = !out_valid_q || out_ready;

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

/* hdl/clas_ctrl.sv */
// Controller: accepts an item, then steps through its results one per cycle while the output is free.
`timescale 1ns / 1ps

module clas_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  clas_pkg::dp_status_t st,
	output clas_pkg::ctrl_cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EMIT = 2'b10
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d      = state_q;
		cmd.load     = 1'b0;
		cmd.emit     = 1'b0;
		cmd.sel      = clas_pkg::SEL_CLOSE;
		cmd.run_last = 1'b0;
		in_ready     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					if (!st.item_empty) begin
						state_d = ST_EMIT;
					end
				end
			end
			ST_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					priority if (!st.bs_zero) begin
						cmd.sel      = clas_pkg::SEL_BS;
						cmd.run_last = st.bs_one && !st.has_char && !st.has_close;
					end else if (st.has_char) begin
						cmd.sel      = clas_pkg::SEL_CHAR;
						cmd.run_last = !st.has_close;
					end else begin
						cmd.sel      = clas_pkg::SEL_CLOSE;
						cmd.run_last = 1'b1;
					end
					if (cmd.run_last) begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* hdl/command_line_argument_splitter_unit.sv */
// Top level of the command line argument splitter.
// An accepted item loads its emission plan; its R results (0 to 64) then follow in order.
// One result per cycle, set by the single output register, while that register is free;
// held backslashes are one result each. No new item is taken until the last result is out.
// Reset: arst_n clears asynchronously; parser returns to line start, output empty.
`timescale 1ns / 1ps

module command_line_argument_splitter_unit #(
	parameter int MAX_BACKSLASHES = 62,
	parameter int MAX_ARGUMENTS   = 4096
) (
	input logic        clk,
	input logic        arst_n,
	clas_in_if.sink    items,
	clas_out_if.source results
);

	clas_pkg::ctrl_cmd_t  cmd;
	clas_pkg::dp_status_t st;

	clas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (items.valid),
		.in_ready (items.ready),
		.st       (st),
		.cmd      (cmd)
	);

	clas_datapath #(
		.MAX_BACKSLASHES (MAX_BACKSLASHES),
		.MAX_ARGUMENTS   (MAX_ARGUMENTS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (items.data),
		.cmd       (cmd),
		.st        (st),
		.out_data  (results.data),
		.out_valid (results.valid),
		.out_ready (results.ready)
	);

endmodule

/* tb/command_line_argument_splitter_unit_tb.sv */
// Self-checking testbench for the command line argument splitter.
`timescale 1ns / 1ps

module command_line_argument_splitter_unit_tb;
	import clas_pkg::*;

	localparam int MAX_BS    = 62;
	localparam int MAX_ARGS  = 4096;
	localparam int ARG_LIMIT = (MAX_ARGS - 1 > 4095) ? 4095 : MAX_ARGS - 1;
	localparam int RES_LIMIT = 64;

	logic clk;
	logic arst_n;

	clas_in_if  items_if ();
	clas_out_if results_if ();

	command_line_argument_splitter_unit #(
		.MAX_BACKSLASHES(MAX_BS),
		.MAX_ARGUMENTS(MAX_ARGS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.items(items_if),
		.results(results_if)
	);

	in_item_t  line_units[$];
	out_item_t arg_results_due[$];
	out_item_t unit_results[$];
	int        errors;
	bit        stall_mode;
	int        in_gap;
	int        out_gap;

	// parser state mirror
	logic             in_token;
	logic             in_quotes;
	logic             pair_pend;
	logic             clipped;
	int unsigned      held_bs;
	logic [ARG_W-1:0] arg_idx;

	function automatic void reset_parser();
		in_token  = 1'b1;
		in_quotes = 1'b0;
		pair_pend = 1'b0;
		clipped   = 1'b0;
		held_bs   = 0;
		arg_idx   = '0;
	endfunction

	function automatic void emit(input logic [UNIT_W-1:0] u, input logic term);
		out_item_t r;
		r = '0;
		r.out_unit   = u;
		r.arg_end    = term;
		r.arg_number = arg_idx;
		if (unit_results.size() < RES_LIMIT)
			unit_results.push_back(r);
	endfunction

	function automatic void close_arg();
		emit(CH_NUL, 1'b1);
		if (arg_idx < ARG_LIMIT)
			arg_idx++;
		in_token = 1'b0;
	endfunction

	// works out every result one accepted code unit causes
	function automatic void split_unit(input in_item_t it);
		logic [UNIT_W-1:0] u;
		logic              last;
		logic              was_quoted;
		out_item_t         r;
		u    = it.code_unit;
		last = it.line_end;
		unit_results.delete();
		if (pair_pend && u == CH_QUOTE) begin
			pair_pend = 1'b0;
			emit(CH_QUOTE, 1'b0);
		end else begin
			pair_pend = 1'b0;
			if (u == CH_BACKSLASH) begin
				in_token = 1'b1;
				if (held_bs < MAX_BS)
					held_bs++;
				else
					clipped = 1'b1;
			end else if (u == CH_QUOTE) begin
				was_quoted = in_quotes;
				in_token   = 1'b1;
				repeat (held_bs >> 1) emit(CH_BACKSLASH, 1'b0);
				if (held_bs % 2 == 1) begin
					emit(CH_QUOTE, 1'b0);
				end else begin
					in_quotes = !in_quotes;
					if (was_quoted && !last)
						pair_pend = 1'b1;
				end
				held_bs = 0;
			end else if (u == CH_SPACE || u == CH_TAB) begin
				if (in_token) begin
					repeat (held_bs) emit(CH_BACKSLASH, 1'b0);
					held_bs = 0;
					if (in_quotes)
						emit(u, 1'b0);
					else
						close_arg();
				end
			end else begin
				in_token = 1'b1;
				repeat (held_bs) emit(CH_BACKSLASH, 1'b0);
				held_bs = 0;
				emit(u, 1'b0);
			end
		end
		if (last && in_token) begin
			repeat (held_bs) emit(CH_BACKSLASH, 1'b0);
			held_bs = 0;
			close_arg();
		end
		foreach (unit_results[k]) begin
			r = unit_results[k];
			r.run_last       = (k == unit_results.size() - 1);
			r.line_done      = last;
			r.slash_overflow = clipped;
			arg_results_due.push_back(r);
		end
		if (last)
			reset_parser();
	endfunction

	function automatic void add_unit(input logic [UNIT_W-1:0] u, input logic last);
		in_item_t it;
		it.code_unit = u;
		it.line_end  = last;
		line_units.push_back(it);
	endfunction

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			items_if.valid <= 1'b0;
			items_if.data  <= '0;
			in_gap         <= 0;
			stall_mode     <= 1'b1;
		end else begin
			if ($urandom_range(0, 149) == 0)
				stall_mode <= !stall_mode;
			if (items_if.valid && items_if.ready)
				split_unit(items_if.data);
			// hold the transaction until it is taken
			if (!(items_if.valid && !items_if.ready)) begin
				if (in_gap > 0) begin
					in_gap         <= in_gap - 1;
					items_if.valid <= 1'b0;
				end else if (line_units.size() > 60 && stall_mode &&
						$urandom_range(0, 9) == 0) begin
					in_gap         <= $urandom_range(0, 7);
					items_if.valid <= 1'b0;
				end else if (line_units.size() > 0) begin
					items_if.valid <= 1'b1;
					items_if.data  <= line_units.pop_front();
				end else begin
					items_if.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		out_item_t exp_r;
		out_item_t got;
		if (!arst_n) begin
			results_if.ready <= 1'b0;
			out_gap          <= 0;
		end else begin
			if (results_if.valid && results_if.ready) begin
				got = results_if.data;
				if (arg_results_due.size() == 0) begin
					$error("unexpected result: out_unit %h arg_end %b", got.out_unit,
						got.arg_end);
					errors++;
				end else begin
					exp_r = arg_results_due.pop_front();
					if (got.out_unit !== exp_r.out_unit) begin
						$error("out_unit: expected %h, got %h", exp_r.out_unit, got.out_unit);
						errors++;
					end
					if (got.arg_end !== exp_r.arg_end) begin
						$error("arg_end: expected %b, got %b", exp_r.arg_end, got.arg_end);
						errors++;
					end
					if (got.arg_number !== exp_r.arg_number) begin
						$error("arg_number: expected %0d, got %0d", exp_r.arg_number,
							got.arg_number);
						errors++;
					end
					if (got.run_last !== exp_r.run_last) begin
						$error("run_last: expected %b, got %b", exp_r.run_last, got.run_last);
						errors++;
					end
					if (got.line_done !== exp_r.line_done) begin
						$error("line_done: expected %b, got %b", exp_r.line_done,
							got.line_done);
						errors++;
					end
					if (got.slash_overflow !== exp_r.slash_overflow) begin
						$error("slash_overflow: expected %b, got %b", exp_r.slash_overflow,
							got.slash_overflow);
						errors++;
					end
				end
			end
			if (out_gap > 0) begin
				out_gap          <= out_gap - 1;
				results_if.ready <= 1'b0;
			end else if (line_units.size() > 60 && stall_mode &&
					$urandom_range(0, 9) == 0) begin
				out_gap          <= $urandom_range(0, 7);
				results_if.ready <= 1'b0;
			end else begin
				results_if.ready <= 1'b1;
			end
		end
	end

	initial begin
		logic [UNIT_W-1:0] u;
		int                len;
		errors = 0;
		reset_parser();
		arst_n <= 1'b0;

		// separators, zero unit, field extremes
		add_unit(16'h0061, 1'b0);
		add_unit(CH_TAB, 1'b0);
		add_unit(CH_NUL, 1'b0);
		add_unit(CH_SPACE, 1'b0);
		add_unit(16'hFFFF, 1'b1);
		// even run before a quote, doubled quote after a quoted part
		add_unit(CH_BACKSLASH, 1'b0);
		add_unit(CH_BACKSLASH, 1'b0);
		add_unit(CH_QUOTE, 1'b0);
		add_unit(16'h0078, 1'b0);
		add_unit(CH_QUOTE, 1'b0);
		add_unit(CH_QUOTE, 1'b0);
		add_unit(16'h0079, 1'b1);
		// escaped quote inside quotes does not open a pair
		add_unit(CH_QUOTE, 1'b0);
		add_unit(CH_BACKSLASH, 1'b0);
		add_unit(CH_QUOTE, 1'b0);
		add_unit(CH_QUOTE, 1'b0);
		add_unit(CH_QUOTE, 1'b0);
		add_unit(CH_TAB, 1'b1);
		// closing quote on the final unit
		add_unit(CH_QUOTE, 1'b0);
		add_unit(16'h0071, 1'b0);
		add_unit(CH_QUOTE, 1'b1);
		// leading separators, held backslashes flushed by space and line end
		add_unit(CH_SPACE, 1'b0);
		add_unit(CH_SPACE, 1'b0);
		add_unit(CH_BACKSLASH, 1'b0);
		add_unit(CH_SPACE, 1'b0);
		add_unit(CH_BACKSLASH, 1'b1);

		// backslash runs around the clip point
		for (int i = 0; i < 4; i++) begin
			repeat (60 + $urandom_range(0, 10)) add_unit(CH_BACKSLASH, 1'b0);
			add_unit((i % 2) ? 16'h0078 : CH_QUOTE, 1'b0);
			add_unit(16'h0079, 1'b1);
		end

		while (line_units.size() < 470) begin
			len = $urandom_range(1, 24);
			for (int j = 0; j < len; j++) begin
				case ($urandom_range(0, 19))
					0, 1, 2, 3, 4, 5: u = 16'h0061 + 16'($urandom_range(0, 25));
					6, 7: u = CH_SPACE;
					8: u = CH_TAB;
					9, 10, 11: u = CH_QUOTE;
					12, 13, 14: u = CH_BACKSLASH;
					15, 16: u = 16'($urandom_range(0, 65535));
					17: u = $urandom_range(0, 1) ? 16'hFFFF : CH_NUL;
					18: begin
						add_unit(CH_QUOTE, 1'b0);
						u = CH_QUOTE;
					end
					default: begin
						repeat ($urandom_range(1, 5)) add_unit(CH_BACKSLASH, 1'b0);
						u = CH_QUOTE;
					end
				endcase
				add_unit(u, j == len - 1);
			end
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (line_units.size() != 0 || items_if.valid)
			@(posedge clk);
		while (arg_results_due.size() != 0)
			@(posedge clk);
		repeat (RES_LIMIT + 8) @(posedge clk);

		if (errors == 0 && arg_results_due.size() == 0)
			$display("command_line_argument_splitter_unit_tb: PASS");
		else
			$display("command_line_argument_splitter_unit_tb: FAIL");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("command_line_argument_splitter_unit_tb: FAIL");
		$finish;
	end

endmodule
